// ===== rtl/ud64_pkg.sv =====
// ----------------------------------------------------------------------------
// ud64_pkg
// Shared types and constants of the 64-bit restoring unsigned divider.
// ----------------------------------------------------------------------------
package ud64_pkg;

    // Width of every operand and result field on the ports
    localparam int FIELD_W = 64;

    // Default operand width used inside the datapath
    localparam int DATA_WIDTH_DEF = 64;

    // Packed stream widths: two fields per transfer on either side
    localparam int S_TDATA_W = 2 * FIELD_W;
    localparam int M_TDATA_W = 2 * FIELD_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture operands, clear the partial remainder
        logic step;      // one compare-subtract step
        logic load_out;  // move the finished result into the output register
    } t_cmd;

endpackage

// ===== rtl/ud64_datapath.sv =====
// ----------------------------------------------------------------------------
// ud64_datapath
// Partial remainder, quotient and divisor registers with one compare-subtract
// unit, plus the output register that holds a finished result.
// ----------------------------------------------------------------------------
module ud64_datapath #(
    parameter int DATA_WIDTH = ud64_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  ud64_pkg::t_cmd               i_cmd,
    input  logic [ud64_pkg::FIELD_W-1:0] i_dividend,
    input  logic [ud64_pkg::FIELD_W-1:0] i_divisor,
    output logic [ud64_pkg::FIELD_W-1:0] o_quotient,
    output logic [ud64_pkg::FIELD_W-1:0] o_remainder,
    output logic                         o_div_by_zero
);

    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_quo;   // dividend bits shift out the top, quotient in
    logic [DATA_WIDTH-1:0] r_dsr;
    logic                  r_dbz;
    logic [DATA_WIDTH-1:0] r_out_quo;
    logic [DATA_WIDTH-1:0] r_out_rem;
    logic                  r_out_dbz;

    logic [DATA_WIDTH:0]   w_trial;
    logic [DATA_WIDTH:0]   w_diff;
    logic                  w_fits;

    // Bring down the next dividend bit and try the subtract
    assign w_trial = {r_rem, r_quo[DATA_WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign w_fits  = (w_trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= '0;
            r_quo <= i_dividend[DATA_WIDTH-1:0];
            r_dsr <= i_divisor[DATA_WIDTH-1:0];
            r_dbz <= (i_divisor[DATA_WIDTH-1:0] == '0);
        end else if (i_cmd.step) begin
            // A zero divisor always fits: quotient fills with ones and the
            // remainder ends as the dividend
            if (w_fits) begin
                r_rem <= w_diff[DATA_WIDTH-1:0];
            end else begin
                r_rem <= w_trial[DATA_WIDTH-1:0];
            end
            r_quo <= {r_quo[DATA_WIDTH-2:0], w_fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_quo <= r_quo;
            r_out_rem <= r_rem;
            r_out_dbz <= r_dbz;
        end
    end

    assign o_quotient    = ud64_pkg::FIELD_W'(r_out_quo);
    assign o_remainder   = ud64_pkg::FIELD_W'(r_out_rem);
    assign o_div_by_zero = r_out_dbz;

endmodule

// ===== rtl/ud64_ctrl.sv =====
// ----------------------------------------------------------------------------
// ud64_ctrl
// Sequencer of the divider: accepts an operand transfer, counts the
// compare-subtract steps and hands the result to the output register.
// ----------------------------------------------------------------------------
module ud64_ctrl #(
    parameter int DATA_WIDTH = ud64_pkg::DATA_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ud64_pkg::t_cmd o_cmd
);

    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

    ud64_pkg::t_state r_state;
    ud64_pkg::t_state n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_accept;
    logic             w_out_free;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ud64_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ud64_pkg::ST_RUN;
                end
            end
            ud64_pkg::ST_RUN: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = ud64_pkg::ST_DONE;
                end
            end
            ud64_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = ud64_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ud64_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.step     = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_state)
            ud64_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ud64_pkg::ST_RUN: begin
                o_cmd.step = 1'b1;
            end
            ud64_pkg::ST_DONE: begin
                o_cmd.load_out = w_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (w_accept) begin
            n_cnt = '0;
        end else if (o_cmd.step) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ud64_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ud64_pkg::ST_RUN) && (r_cnt == '0))
        else $error("accepted transfer did not start a division");

    a_last_step_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ud64_pkg::ST_RUN) && (r_cnt == CNT_LAST)
        |=> r_state == ud64_pkg::ST_DONE)
        else $error("division did not finish after the last step");

    a_load_out_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_out_valid && (r_state == ud64_pkg::ST_IDLE))
        else $error("result handoff did not raise the output valid");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result handoff over a result not yet taken");

endmodule

// ===== rtl/unsigned_divider_64_core.sv =====
// ----------------------------------------------------------------------------
// unsigned_divider_64_core
// Restoring unsigned divider returning quotient and remainder together.
//
// Usage:
//   Operands arrive on the s_axis channel, one dividend/divisor pair per
//   transfer. Results leave on the m_axis channel, one transfer per operand
//   pair, with the zero-divisor flag in tuser. Only the low DATA_WIDTH bits of
//   each operand are used; results are zero-extended to 64 bits.
//   After the input transfer the shared compare-subtract unit takes one step
//   per cycle, one for each quotient bit, and then the result moves into
//   the output register once that register is free. The single
//   compare-subtract unit is reused for every quotient bit, so one division
//   is in flight at a time; the next operand pair is taken only after the
//   current division has handed its result to the output register.
//   A finished result sits in its own output register, so the next operand
//   pair is taken while the previous result still waits for the receiver.
//   When the receiver stalls and a second division finishes, that division
//   holds in the done state until the output register frees up.
//   Zero divisor: quotient is all ones, remainder is the dividend, tuser is 1.
//   Reset (synchronous, active low) drops any division in progress and any
//   result not yet taken; the block comes up ready for input.
// ----------------------------------------------------------------------------
module unsigned_divider_64_core #(
    parameter int DATA_WIDTH = ud64_pkg::DATA_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Operand channel
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ud64_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [63:0] dividend, [127:64] divisor
    // Result channel
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [ud64_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [63:0] quotient, [127:64] remainder
    output logic                           m_axis_tuser   // [0] div_by_zero
);

    ud64_pkg::t_cmd                 w_cmd;
    logic [ud64_pkg::FIELD_W-1:0]   w_quotient;
    logic [ud64_pkg::FIELD_W-1:0]   w_remainder;

    // Sequencer: handshakes and step count
    ud64_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    // Datapath: shift-and-subtract registers and the output register
    ud64_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .i_dividend    (s_axis_tdata[ud64_pkg::FIELD_W-1:0]),
        .i_divisor     (s_axis_tdata[2*ud64_pkg::FIELD_W-1:ud64_pkg::FIELD_W]),
        .o_quotient    (w_quotient),
        .o_remainder   (w_remainder),
        .o_div_by_zero (m_axis_tuser)
    );

    // Pack quotient low, remainder high
    assign m_axis_tdata = {w_remainder, w_quotient};

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 64-bit restoring unsigned divider. A short
// list of directed operand pairs covers the extremes and the zero divisor;
// after it come random pairs of mixed magnitude. Each accepted pair takes
// its expected result from a typed row or a shift-and-subtract predictor,
// and each result is compared with the oldest pending quotient/remainder;
// both stream sides stall at random in the first two idling phases.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          OPER_W      = ud64_pkg::DATA_WIDTH_DEF;
    localparam logic [63:0] ALL_ONES    = '1;
    localparam logic [63:0] TOP_ONE     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] TOP_LESS    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          N_DIRECTED  = 18;
    localparam int          N_RANDOM    = 1450;
    localparam int          N_TOTAL     = N_DIRECTED + N_RANDOM;
    localparam int          STALL_LIMIT = 5000;
    localparam int          TAIL_CYCLES = OPER_W + 8;

    typedef struct packed {
        logic [63:0] quotient;
        logic [63:0] remainder;
        logic        div_by_zero;
    } t_quot_rem;

    // One directed pair; has_typed selects the typed result over the predictor
    typedef struct packed {
        logic [63:0] dividend;
        logic [63:0] divisor;
        logic        has_typed;
        t_quot_rem   typed_res;
    } t_operand_row;

    logic                           i_clk          = 1'b0;
    logic                           i_rst_n        = 1'b0;
    logic                           s_axis_tvalid  = 1'b0;
    logic                           s_axis_tready;
    logic [ud64_pkg::S_TDATA_W-1:0] s_axis_tdata   = '0;  // [63:0] dividend, [127:64] divisor
    logic                           m_axis_tvalid;
    logic                           m_axis_tready  = 1'b0;
    logic [ud64_pkg::M_TDATA_W-1:0] m_axis_tdata;         // [63:0] quotient, [127:64] remainder
    logic                           m_axis_tuser;         // [0] div_by_zero

    t_quot_rem pending_quotients[$];
    int        mismatch_count = 0;
    int        stall_cycles   = 0;
    int        src_idle_pct   = 26;
    int        dst_idle_pct   = 72;

    t_operand_row directed_rows [N_DIRECTED] = '{
        // zero divisor: all-ones quotient, dividend comes back as remainder
        '{64'd0,     64'd0,     1'b1, '{ALL_ONES, 64'd0,    1'b1}},
        '{ALL_ONES,  64'd0,     1'b1, '{ALL_ONES, ALL_ONES, 1'b1}},
        '{64'h0123_4567_89AB_CDEF, 64'd0, 1'b1,
          '{ALL_ONES, 64'h0123_4567_89AB_CDEF, 1'b1}},
        '{64'd0,     64'd1,     1'b1, '{64'd0,    64'd0,    1'b0}},
        '{ALL_ONES,  64'd1,     1'b1, '{ALL_ONES, 64'd0,    1'b0}},
        '{ALL_ONES,  ALL_ONES,  1'b1, '{64'd1,    64'd0,    1'b0}},
        '{64'd0,     ALL_ONES,  1'b1, '{64'd0,    64'd0,    1'b0}},
        '{TOP_ONE,   TOP_ONE,   1'b1, '{64'd1,    64'd0,    1'b0}},
        '{TOP_LESS,  TOP_ONE,   1'b1, '{64'd0,    TOP_LESS, 1'b0}},
        '{TOP_ONE,   64'd1,     1'b1, '{TOP_ONE,  64'd0,    1'b0}},
        '{64'd1,     TOP_ONE,   1'b1, '{64'd0,    64'd1,    1'b0}},
        '{64'd100,   64'd7,     1'b1, '{64'd14,   64'd2,    1'b0}},
        '{64'd1,     64'd1,     1'b1, '{64'd1,    64'd0,    1'b0}},
        '{64'd5,     64'd10,    1'b1, '{64'd0,    64'd5,    1'b0}},
        '{ALL_ONES,  64'd2,     1'b0, '0},
        '{ALL_ONES,  64'hFFFF_FFFF, 1'b0, '0},
        '{ALL_ONES,  64'd3,     1'b0, '0},
        '{64'hDEAD_BEEF_0BAD_F00D, 64'h0000_0001_2345_6789, 1'b0, '0}
    };

    unsigned_divider_64_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Normalize the divisor, then one compare-subtract per quotient bit
    function automatic t_quot_rem divide_restoring(logic [63:0] dividend,
                                                   logic [63:0] divisor);
        t_quot_rem   res;
        logic [63:0] shifted;
        int          zeros;
        res = '0;
        if (divisor == '0) begin
            res.quotient    = ALL_ONES;
            res.remainder   = dividend;
            res.div_by_zero = 1'b1;
            return res;
        end
        zeros = 0;
        while (!divisor[OPER_W-1-zeros]) zeros++;
        shifted       = divisor << zeros;
        res.remainder = dividend;
        for (int pos = zeros; pos >= 0; pos--) begin
            if (res.remainder >= shifted) begin
                res.remainder     -= shifted;
                res.quotient[pos]  = 1'b1;
            end
            shifted >>= 1;
        end
        return res;
    endfunction

    // Random word of random magnitude, sometimes with the top bit forced
    function automatic logic [63:0] random_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return w;
            1: return w >> $urandom_range(1, 63);
            2: return w | TOP_ONE;
            default: return w >> $urandom_range(32, 63);
        endcase
    endfunction

    task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch in %s: expected %h, got %h", field, want, got);
    endtask

    // Offer one operand pair and hold it until the transfer; called at a falling edge
    task automatic send_operands(logic [63:0] dividend, logic [63:0] divisor,
                                 logic has_typed, t_quot_rem typed_res);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {divisor, dividend};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_quotients.push_back(has_typed ? typed_res
                                              : divide_restoring(dividend, divisor));
        @(negedge i_clk);
    endtask

    // Receiver stalls at random; ready changes only on the falling edge
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    // Compare every result transfer with the oldest pending quotient
    always @(posedge i_clk) begin
        t_quot_rem want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_quotients.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: quotient %h remainder %h flag %b",
                             m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tuser);
            end else begin
                want = pending_quotients.pop_front();
                if (m_axis_tdata[63:0] !== want.quotient)
                    note_mismatch("quotient", want.quotient, m_axis_tdata[63:0]);
                if (m_axis_tdata[127:64] !== want.remainder)
                    note_mismatch("remainder", want.remainder, m_axis_tdata[127:64]);
                if (m_axis_tuser !== want.div_by_zero)
                    note_mismatch("div_by_zero", 64'(want.div_by_zero),
                                  64'(m_axis_tuser));
            end
        end
    end

    // Abort when no transfer happens on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [63:0] dividend;
        logic [63:0] divisor;
        int          shape;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int item = 0; item < N_TOTAL; item++) begin
            // three idling phases: sender light / receiver heavy, swapped, none
            case (item * 3 / N_TOTAL)
                0: begin src_idle_pct = 26; dst_idle_pct = 72; end
                1: begin src_idle_pct = 72; dst_idle_pct = 26; end
                default: begin src_idle_pct = 0; dst_idle_pct = 0; end
            endcase
            if (item < N_DIRECTED) begin
                send_operands(directed_rows[item].dividend, directed_rows[item].divisor,
                              directed_rows[item].has_typed,
                              directed_rows[item].typed_res);
            end else begin
                shape    = $urandom_range(0, 19);
                dividend = random_word();
                divisor  = random_word();
                if (shape == 0) divisor = '0;
                else if (shape < 3) dividend = divisor - 64'($urandom_range(0, 1));
                else if (shape < 5) divisor = 64'($urandom_range(1, 255));
                send_operands(dividend, divisor, 1'b0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_quotients.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_quotients.size() != 0) mismatch_count++;

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
